// ===== rtl/md5_hash_engine_unit_macros.svh =====
// Assertion macros shared by the MD5 engine RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MD5_HASH_ENGINE_UNIT_MACROS_SVH
`define MD5_HASH_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MD5HE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("md5he: invariant violated");
`define MD5HE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5he: implication violated");
`define MD5HE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5he: next-cycle implication violated");
`else
`define MD5HE_ASSERT_ALWAYS(label, expr)
`define MD5HE_ASSERT_IMPLIES(label, ante, cons)
`define MD5HE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/md5he_pkg.sv =====
// Shared types, constants and round tables for the MD5 engine.
// Used by md5he_ctrl, md5he_datapath and md5_hash_engine_unit; no dependencies.
`timescale 1ns / 1ps

package md5he_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_COMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WS_BYTE,
    WS_PAD80,
    WS_ZERO,
    WS_LEN
  } wsel_t;

  typedef struct packed {
    logic       wr_en;
    wsel_t      wr_sel;
    logic       count_add;
    logic       rd_issue;
    logic [5:0] rd_round;
    logic       load_work;
    logic       chain_add;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_len;
    logic out_busy;
  } sts_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [6:0] ROUNDS     = 7'd64;
  localparam logic [6:0] COMP_LAST  = 7'd66;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  function automatic logic [31:0] k_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Message word used by each round: identity, then 5j+1, 3j+5 and 7j, all modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] j;
    logic [3:0] m;
    j = r[3:0];
    case (r[5:4])
      2'd0:    m = j;
      2'd1:    m = 4'd1 + j + (j << 2);
      2'd2:    m = 4'd5 + j + (j << 1);
      default: m = j + (j << 1) + (j << 2);
    endcase
    return m;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/md5he_datapath.sv =====
// MD5 datapath: block buffer memory, round pipeline, chaining words, counters
// and the digest output buffer. Depends on md5he_pkg and the macros header.
`timescale 1ns / 1ps
`include "md5_hash_engine_unit_macros.svh"

module md5he_datapath (
  input  logic              clk,
  input  logic              rst,
  input  md5he_pkg::cmd_t   cmd,
  output md5he_pkg::sts_t   sts,
  input  logic [7:0]        data_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       digest_word,
  output logic [1:0]        word_index,
  output logic              last_word
);

  logic [31:0] mem [16];
  logic [31:0] rdata;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic        v1, v2;
  logic [5:0]  r1, r2;
  logic [31:0] wk;
  logic [31:0] obuf [4];
  logic [1:0]  out_idx;

  logic [7:0]  wdata;
  logic [31:0] mix;
  logic [31:0] t;
  logic [63:0] rot_wide;
  logic [31:0] b_new;

  always_comb begin
    case (cmd.wr_sel)
      md5he_pkg::WS_BYTE:  wdata = data_byte;
      md5he_pkg::WS_PAD80: wdata = md5he_pkg::PAD_BYTE;
      md5he_pkg::WS_ZERO:  wdata = 8'h00;
      default:             wdata = 8'(bit_count >> {fill[2:0], 3'b000});
    endcase
  end

  // Byte-wide writes into a word-organised buffer; one registered word read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= wdata;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[md5he_pkg::msg_index(cmd.rd_round)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      chain[0]  <= md5he_pkg::IV_A;
      chain[1]  <= md5he_pkg::IV_B;
      chain[2]  <= md5he_pkg::IV_C;
      chain[3]  <= md5he_pkg::IV_D;
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else begin
      v1 <= cmd.rd_issue;
      v2 <= v1;
      if (cmd.wr_en) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_add) begin
        bit_count <= bit_count + md5he_pkg::BYTE_BITS;
      end
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
      if (cmd.emit) begin
        chain[0]  <= md5he_pkg::IV_A;
        chain[1]  <= md5he_pkg::IV_B;
        chain[2]  <= md5he_pkg::IV_C;
        chain[3]  <= md5he_pkg::IV_D;
        bit_count <= '0;
        out_valid <= 1'b1;
        out_idx   <= '0;
      end else if (out_valid && out_ready) begin
        out_idx <= out_idx + 2'd1;
        if (out_idx == 2'd3) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers of the round pipeline and the output buffer.
  always_ff @(posedge clk) begin
    r1 <= cmd.rd_round;
    r2 <= r1;
    wk <= rdata + md5he_pkg::k_const(r1);
    if (cmd.load_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (v2) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= b_new;
    end
    if (cmd.emit) begin
      obuf[0] <= chain[0];
      obuf[1] <= chain[1];
      obuf[2] <= chain[2];
      obuf[3] <= chain[3];
    end
  end

  always_comb begin
    case (r2[5:4])
      2'd0:    mix = (wb & wc) | (~wb & wd);
      2'd1:    mix = (wb & wd) | (wc & ~wd);
      2'd2:    mix = wb ^ wc ^ wd;
      default: mix = wc ^ (wb | ~wd);
    endcase
    t        = wa + mix + wk;
    rot_wide = {t, t} << md5he_pkg::rot_amount(r2);
    b_new    = wb + rot_wide[63:32];
  end

  assign sts.fill_full = (fill == md5he_pkg::FILL_LAST);
  assign sts.fill_len  = (fill == md5he_pkg::LEN_POS);
  assign sts.out_busy  = out_valid;

  assign digest_word = obuf[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 2'd3);

  `MD5HE_ASSERT_IMPLIES(a_emit_into_free_buffer, cmd.emit, !out_valid)
  `MD5HE_ASSERT_IMPLIES(a_no_write_during_rounds, cmd.wr_en, !(v1 || v2 || cmd.rd_issue))
  `MD5HE_ASSERT_ALWAYS(a_count_whole_bytes, bit_count[2:0] == 3'd0)

endmodule

// ===== rtl/md5he_ctrl.sv =====
// MD5 controller: sequences byte intake, padding, compression and digest hand-off.
// Depends on md5he_pkg; drives md5he_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module md5he_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              byte_present,
  input  logic              last,
  input  md5he_pkg::sts_t   sts,
  output md5he_pkg::cmd_t   cmd
);

  md5he_pkg::state_t state, state_next;
  md5he_pkg::state_t ret, ret_next;
  logic [6:0]        cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5he_pkg::ST_IDLE;
      ret   <= md5he_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      md5he_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (byte_present) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = md5he_pkg::WS_BYTE;
            cmd.count_add = 1'b1;
          end
          // A byte that completes the block is compressed before any padding.
          if (byte_present && sts.fill_full) begin
            ret_next   = last ? md5he_pkg::ST_PAD80 : md5he_pkg::ST_IDLE;
            cnt_next   = '0;
            state_next = md5he_pkg::ST_COMP;
          end else if (last) begin
            state_next = md5he_pkg::ST_PAD80;
          end
        end
      end
      md5he_pkg::ST_PAD80: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = md5he_pkg::WS_PAD80;
        if (sts.fill_full) begin
          ret_next   = md5he_pkg::ST_PADZ;
          cnt_next   = '0;
          state_next = md5he_pkg::ST_COMP;
        end else begin
          state_next = md5he_pkg::ST_PADZ;
        end
      end
      md5he_pkg::ST_PADZ: begin
        if (sts.fill_len) begin
          state_next = md5he_pkg::ST_PADLEN;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = md5he_pkg::WS_ZERO;
          if (sts.fill_full) begin
            ret_next   = md5he_pkg::ST_PADZ;
            cnt_next   = '0;
            state_next = md5he_pkg::ST_COMP;
          end
        end
      end
      md5he_pkg::ST_PADLEN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = md5he_pkg::WS_LEN;
        if (sts.fill_full) begin
          ret_next   = md5he_pkg::ST_DONE;
          cnt_next   = '0;
          state_next = md5he_pkg::ST_COMP;
        end
      end
      md5he_pkg::ST_COMP: begin
        // Reads pass the rdata and wk registers before the round unit; the final add follows the last round.
        cmd.rd_issue  = (cnt < md5he_pkg::ROUNDS);
        cmd.rd_round  = cnt[5:0];
        cmd.load_work = (cnt == '0);
        cmd.chain_add = (cnt == md5he_pkg::COMP_LAST);
        cnt_next      = cnt + 7'd1;
        if (cnt == md5he_pkg::COMP_LAST) begin
          state_next = ret;
        end
      end
      md5he_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = md5he_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = md5he_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/md5_hash_engine_unit.sv =====
// MD5 engine: one message byte per item; a byte that neither fills a block nor is last is
// simply stored. A byte completing a 64-byte block starts a compression, one round per cycle
// on one shared round unit fed from a block memory with byte writes and one word read port.
// A last item adds padding (at most one byte written per cycle) and one or two compressions,
// then loads the output buffer when free; four digest items leave while new bytes come.
// Synchronous reset restores the initial chaining words and clears all counters.
`timescale 1ns / 1ps

module md5_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5he_pkg::cmd_t cmd;
  md5he_pkg::sts_t sts;

  md5he_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_present (byte_present),
    .last         (last),
    .sts          (sts),
    .cmd          (cmd)
  );

  md5he_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (data_byte),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
